### hw/rtl/rbd_pkg.sv
// Package for the ray/box entry distance block.
// Holds field widths, register indexes, result codes and payload types.
// No dependencies.
package rbd_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIR_W   = 32;
  localparam int unsigned HALF_W  = 31;
  localparam int unsigned DIST_W  = 31;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DIV_BITS_PER_STAGE = 4;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_HALF_X   = 3'd3,
    REG_HALF_Y   = 3'd4,
    REG_HALF_Z   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    OUT_HIT    = 2'd0,
    OUT_INSIDE = 2'd1,
    OUT_MISS   = 2'd2,
    OUT_FAR    = 2'd3
  } outcome_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
    logic [HALF_W-1:0]         step_limit;
  } ray_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        outcome;
  } res_t;

  typedef struct packed {
    logic       far;
    logic       in_box;
    logic [2:0] ok;
    logic [2:0] sat;
  } flags_t;

endpackage

### hw/rtl/rbd_ray_if.sv
// Ray input channel: valid/ready handshake carrying one ray item.
// Depends on rbd_pkg.
interface rbd_ray_if;
  import rbd_pkg::*;
  logic valid;
  logic ready;
  ray_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/rbd_res_if.sv
// Result output channel: valid/ready handshake carrying one result item.
// Depends on rbd_pkg.
interface rbd_res_if;
  import rbd_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/rbd_div.sv
// Pipelined restoring divider: floor((num << 30) / den), 31 quotient bits.
// Caller guarantees num < 2*den where the quotient is used. Depends on rbd_pkg.
module rbd_div #(
  parameter int unsigned BITS_PER_STAGE = rbd_pkg::DIV_BITS_PER_STAGE
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [31:0]               num_i,
  input  logic [31:0]               den_i,
  output logic [rbd_pkg::DIST_W-1:0] quo_o
);
  import rbd_pkg::*;

  localparam int unsigned NST = (DIST_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  logic [32:0]       rem_q [NST];
  logic [DIST_W-1:0] quo_q [NST];
  logic [31:0]       den_q [NST];

  for (genvar st = 0; st < NST; st++) begin : g_stage
    logic [32:0]       rem_in;
    logic [DIST_W-1:0] quo_in;
    logic [31:0]       den_in;
    logic [32:0]       rem_c;
    logic [DIST_W-1:0] quo_c;

    if (st == 0) begin : g_first
      assign rem_in = {2'b00, num_i[31:1]};
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[st-1];
      assign quo_in = quo_q[st-1];
      assign den_in = den_q[st-1];
    end

    always_comb begin
      rem_c = rem_in;
      quo_c = quo_in;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        if (st * BITS_PER_STAGE + b < DIST_W) begin
          rem_c = {rem_c[31:0], (st == 0 && b == 0) ? num_i[0] : 1'b0};
          if (rem_c >= {1'b0, den_in}) begin
            rem_c = rem_c - {1'b0, den_in};
            quo_c = {quo_c[DIST_W-2:0], 1'b1};
          end else begin
            quo_c = {quo_c[DIST_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[st] <= rem_c;
        quo_q[st] <= quo_c;
        den_q[st] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[NST-1];

endmodule

### hw/rtl/ray_box_distance_from_outside_core.sv
// Ray to axis-aligned box entry distance, one ray item per cycle.
// Registered steps: centre offsets, safeties, cross products, in-face tests, divider stages, output.
// Throughput: one item per cycle; the whole pipeline holds while the result stalls.
// Depth grows with the three per-face restoring dividers, whose stage count BITS_PER_STAGE sets.
// Reset clears all valid bits and the box registers (centre and half-lengths to 0).
module ray_box_distance_from_outside_core #(
  parameter int unsigned BITS_PER_STAGE = rbd_pkg::DIV_BITS_PER_STAGE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rbd_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [rbd_pkg::COORD_W-1:0] cfg_data_i,
  rbd_ray_if.sink                     ray_i,
  rbd_res_if.source                   res_o
);
  import rbd_pkg::*;

  localparam int unsigned NST    = (DIST_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int unsigned NSTAGE = 5 + NST;

  logic signed [COORD_W-1:0] center_q [3];
  logic [HALF_W-1:0]         half_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        center_q[i] <= '0;
        half_q[i]   <= '0;
      end
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CENTER_X: center_q[0] <= cfg_data_i;
        REG_CENTER_Y: center_q[1] <= cfg_data_i;
        REG_CENTER_Z: center_q[2] <= cfg_data_i;
        REG_HALF_X:   half_q[0]   <= cfg_data_i[HALF_W-1:0];
        REG_HALF_Y:   half_q[1]   <= cfg_data_i[HALF_W-1:0];
        REG_HALF_Z:   half_q[2]   <= cfg_data_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  logic              en;
  logic [NSTAGE-1:0] vld_q;

  assign en          = !vld_q[NSTAGE-1] || res_o.ready;
  assign ray_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTAGE-2:0], ray_i.valid};
    end
  end

  // stage 1: offsets from the centre
  logic signed [COORD_W:0]   rel_q [3];
  logic [DIR_W-1:0]          dir_q [3];
  logic [HALF_W-1:0]         lim_q;
  logic signed [COORD_W-1:0] pt [3];
  logic [DIR_W-1:0]          dr [3];

  assign pt[0] = ray_i.data.point_x;
  assign pt[1] = ray_i.data.point_y;
  assign pt[2] = ray_i.data.point_z;
  assign dr[0] = ray_i.data.dir_x;
  assign dr[1] = ray_i.data.dir_y;
  assign dr[2] = ray_i.data.dir_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rel_q[i] <= {pt[i][COORD_W-1], pt[i]} - {center_q[i][COORD_W-1], center_q[i]};
        dir_q[i] <= dr[i];
      end
      lim_q <= ray_i.data.step_limit;
    end
  end

  // stage 2: safeties and face candidates
  logic [31:0] arel_q [3];
  logic [31:0] ad_q [3];
  logic [31:0] s_q [3];
  logic [2:0]  rneg_q, dneg_q, cand_q;
  logic        far_q, inside_q;

  logic [32:0] amag_c [3];
  logic [33:0] saf_c [3];
  logic [31:0] ad_c [3];
  logic [2:0]  cand_c;
  logic        far_c, inside_c;

  always_comb begin
    far_c    = 1'b0;
    inside_c = 1'b1;
    for (int i = 0; i < 3; i++) begin
      amag_c[i] = rel_q[i][COORD_W] ? 33'(-rel_q[i]) : 33'(rel_q[i]);
      saf_c[i]  = {2'b00, amag_c[i][31:0]} - {3'b000, half_q[i]};
      ad_c[i]   = dir_q[i][DIR_W-1] ? 32'(-dir_q[i]) : dir_q[i];
      if (!saf_c[i][33] && saf_c[i][32:0] >= {2'b00, lim_q}) far_c = 1'b1;
      if (!saf_c[i][33]) inside_c = 1'b0;
      cand_c[i] = !saf_c[i][33] && (saf_c[i] != '0) && (dir_q[i] != '0) &&
                  (rel_q[i][COORD_W] != dir_q[i][DIR_W-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        arel_q[i] <= amag_c[i][31:0];
        ad_q[i]   <= ad_c[i];
        s_q[i]    <= saf_c[i][31:0];
        rneg_q[i] <= rel_q[i][COORD_W];
        dneg_q[i] <= dir_q[i][DIR_W-1];
      end
      cand_q   <= cand_c;
      far_q    <= far_c;
      inside_q <= inside_c;
    end
  end

  // stage 3: cross products for the in-face tests
  logic [63:0] ma_q [3][2];
  logic [63:0] mb_q [3][2];
  logic [62:0] hb_q [3][2];
  logic        na_q [3][2];
  logic        nb_q [3][2];
  logic [31:0] s3_q [3];
  logic [31:0] ad3_q [3];
  logic [2:0]  cand3_q;
  logic        far3_q, inside3_q;

  for (genvar i = 0; i < 3; i++) begin : g_prod
    for (genvar n = 0; n < 2; n++) begin : g_other
      localparam int unsigned J = (i + 1 + n) % 3;
      always_ff @(posedge clk_i) begin
        if (en) begin
          ma_q[i][n] <= {32'd0, arel_q[J]} * {32'd0, ad_q[i]};
          mb_q[i][n] <= {32'd0, s_q[i]} * {32'd0, ad_q[J]};
          hb_q[i][n] <= {32'd0, half_q[J]} * {31'd0, ad_q[i]};
          na_q[i][n] <= rneg_q[J];
          nb_q[i][n] <= dneg_q[J];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q      <= s_q;
      ad3_q     <= ad_q;
      cand3_q   <= cand_q;
      far3_q    <= far_q;
      inside3_q <= inside_q;
    end
  end

  // stage 4: in-face decisions and saturation check
  logic [31:0] s4_q [3];
  logic [31:0] ad4_q [3];
  flags_t      fl4_q;
  flags_t      fl4_c;
  logic [63:0] m_c [3][2];
  logic        w_c [3][2];

  always_comb begin
    fl4_c.far    = far3_q;
    fl4_c.in_box = inside3_q;
    for (int i = 0; i < 3; i++) begin
      for (int n = 0; n < 2; n++) begin
        if (ma_q[i][n] == '0 || mb_q[i][n] == '0 || na_q[i][n] == nb_q[i][n]) begin
          m_c[i][n] = ma_q[i][n] + mb_q[i][n];
        end else if (ma_q[i][n] > mb_q[i][n]) begin
          m_c[i][n] = ma_q[i][n] - mb_q[i][n];
        end else begin
          m_c[i][n] = mb_q[i][n] - ma_q[i][n];
        end
        w_c[i][n] = m_c[i][n] <= {1'b0, hb_q[i][n]};
      end
      fl4_c.ok[i]  = cand3_q[i] && w_c[i][0] && w_c[i][1];
      fl4_c.sat[i] = {1'b0, s3_q[i]} >= {ad3_q[i], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q  <= s3_q;
      ad4_q <= ad3_q;
      fl4_q <= fl4_c;
    end
  end

  // division stages
  logic [DIST_W-1:0] quo [3];
  flags_t            fl_q [NST];

  for (genvar i = 0; i < 3; i++) begin : g_div
    rbd_div #(
      .BITS_PER_STAGE(BITS_PER_STAGE)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s4_q[i]),
      .den_i (ad4_q[i]),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= fl4_q;
      for (int t = 1; t < NST; t++) fl_q[t] <= fl_q[t-1];
    end
  end

  // output stage: entry face is the farthest hit face
  flags_t            fl_o;
  logic [DIST_W-1:0] dq_c [3];
  logic [DIST_W-1:0] best_c;
  res_t              res_c;
  res_t              res_q;

  assign fl_o = fl_q[NST-1];

  always_comb begin
    best_c = '0;
    for (int i = 0; i < 3; i++) begin
      dq_c[i] = fl_o.sat[i] ? DIST_MAX : quo[i];
      if (fl_o.ok[i] && dq_c[i] > best_c) best_c = dq_c[i];
    end
    if (fl_o.far) begin
      res_c.distance = DIST_MAX;
      res_c.outcome  = OUT_FAR;
    end else if (fl_o.in_box) begin
      res_c.distance = '0;
      res_c.outcome  = OUT_INSIDE;
    end else if (fl_o.ok != '0) begin
      res_c.distance = best_c;
      res_c.outcome  = OUT_HIT;
    end else begin
      res_c.distance = DIST_MAX;
      res_c.outcome  = OUT_MISS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_c;
  end

  assign res_o.valid = vld_q[NSTAGE-1];
  assign res_o.data  = res_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |-> ray_i.ready)
    else $error("input stalled with an empty output stage");

  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.outcome == OUT_INSIDE |-> res_o.data.distance == '0)
    else $error("inside item with nonzero distance");

  a_nohit_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.data.outcome == OUT_MISS || res_o.data.outcome == OUT_FAR)
      |-> res_o.data.distance == DIST_MAX)
    else $error("miss or far item without maximum distance");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTAGE-2] && !en |=> vld_q[NSTAGE-2])
    else $error("item lost in pipeline during stall");

endmodule

### test/tb.sv
// Self-checking bench for ray_box_distance_from_outside_core: random and directed rays
// against a range of boxes, results checked against a behavioural entry-distance model.
// Depends on rbd_pkg, rbd_ray_if, rbd_res_if and the core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbd_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int LATENCY = 13;
  localparam int HOLD_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [COORD_W-1:0] cfg_data_i = '0;

  rbd_ray_if ray_ch();
  rbd_res_if res_ch();

  ray_box_distance_from_outside_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .ray_i(ray_ch.sink), .res_o(res_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic signed [63:0] box_c [3];
  logic [63:0] box_h [3];
  ray_t ray_q [$];
  res_t want_q [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int phase = -1;
  bit hold_off = 1'b0;
  int quiet = 0;

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit crosses_within(logic signed [63:0] rel, logic [63:0] saf,
                                        logic signed [63:0] dj, logic [63:0] ad,
                                        logic [63:0] half);
    logic [63:0] ma, mb, m;
    ma = mag64(rel) * ad;
    mb = saf * mag64(dj);
    if (ma == 0 || mb == 0 || (rel < 0) == (dj < 0)) m = ma + mb;
    else m = ma > mb ? ma - mb : mb - ma;
    return m <= half * ad;
  endfunction

  function automatic res_t entry_distance(ray_t r);
    logic signed [63:0] rel [3], saf [3], dv [3];
    logic signed [63:0] lim;
    logic [63:0] best, s, ad, q;
    bit hit, far, in_box;
    int j, k;
    res_t o;
    rel[0] = $signed(r.point_x) - box_c[0];
    rel[1] = $signed(r.point_y) - box_c[1];
    rel[2] = $signed(r.point_z) - box_c[2];
    dv[0] = $signed(r.dir_x);
    dv[1] = $signed(r.dir_y);
    dv[2] = $signed(r.dir_z);
    lim = {33'd0, r.step_limit};
    best = 0; hit = 0; far = 0; in_box = 1;
    for (int i = 0; i < 3; i++) begin
      saf[i] = $signed(mag64(rel[i])) - $signed(box_h[i]);
      if (saf[i] >= lim) far = 1;
      if (saf[i] >= 0) in_box = 0;
    end
    if (far) begin
      o.distance = DIST_MAX; o.outcome = OUT_FAR;
      return o;
    end
    if (in_box) begin
      o.distance = '0; o.outcome = OUT_INSIDE;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3; k = (i + 2) % 3;
      if (saf[i] <= 0 || dv[i] == 0) continue;
      if ((rel[i] < 0) == (dv[i] < 0)) continue;
      s = saf[i]; ad = mag64(dv[i]);
      if (!crosses_within(rel[j], s, dv[j], ad, box_h[j])) continue;
      if (!crosses_within(rel[k], s, dv[k], ad, box_h[k])) continue;
      q = (s << 30) / ad;
      if (q > DIST_MAX) q = DIST_MAX;
      if (!hit || q > best) best = q;
      hit = 1;
    end
    o.distance = hit ? best[30:0] : DIST_MAX;
    o.outcome = hit ? OUT_HIT : OUT_MISS;
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (ray_ch.valid && ray_ch.ready) begin
      want_q.push_back(entry_distance(ray_ch.data));
      void'(ray_q.pop_front());
    end
    if ((!ray_ch.valid || ray_ch.ready) && ray_q.size() > 0) begin
      if ($urandom_range(99) >= idle_pct) begin
        ray_ch.valid <= 1'b1;
        ray_ch.data <= ray_q[0];
      end else ray_ch.valid <= 1'b0;
    end else if (ray_ch.valid && ray_ch.ready) ray_ch.valid <= 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    res_t w;
    if (res_ch.valid && res_ch.ready) begin
      if (want_q.size() == 0) begin
        $error("unexpected result item %h", res_ch.data);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (res_ch.data.distance !== w.distance) begin
          $error("distance: expected %h, got %h", w.distance, res_ch.data.distance);
          errors++;
        end
        if (res_ch.data.outcome !== w.outcome) begin
          $error("outcome: expected %0d, got %0d", w.outcome, res_ch.data.outcome);
          errors++;
        end
      end
    end
    res_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off in the third phase
  initial begin
    wait (phase == 2);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready) || hold_off) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx <= REG_CENTER_Z) box_c[idx] = $signed(val);
    else box_h[idx - REG_HALF_X] = val[30:0];
  endtask

  task automatic drain();
    wait (ray_q.size() == 0 && !ray_ch.valid);
    wait (want_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                         logic [30:0] hx, logic [30:0] hy, logic [30:0] hz);
    write_reg(REG_CENTER_X, cx); write_reg(REG_CENTER_Y, cy); write_reg(REG_CENTER_Z, cz);
    write_reg(REG_HALF_X, {1'b0, hx}); write_reg(REG_HALF_Y, {1'b0, hy});
    write_reg(REG_HALF_Z, {1'b0, hz});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_dir();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h4000_0000;
      2: return 32'hC000_0000;
      3: return $urandom();
      default: return $signed($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rnd_coord(int axis);
    logic [31:0] span;
    if ($urandom_range(9) == 0) return $urandom();
    span = box_h[axis][30:0] * 3 + 32'h10;
    return box_c[axis][31:0] + ($urandom_range(span) - span / 2) + $urandom_range(3) - 1;
  endfunction

  task automatic push_rand(int n);
    ray_t r;
    for (int i = 0; i < n; i++) begin
      r.point_x = rnd_coord(0); r.point_y = rnd_coord(1); r.point_z = rnd_coord(2);
      r.dir_x = rnd_dir(); r.dir_y = rnd_dir(); r.dir_z = rnd_dir();
      case ($urandom_range(3))
        0: r.step_limit = $urandom();
        1: r.step_limit = 31'h7FFF_FFFF;
        2: r.step_limit = $urandom_range(32'h0004_0000);
        default: r.step_limit = 31'h0100_0000;
      endcase
      ray_q.push_back(r);
    end
  endtask

  task automatic push_ray(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                          logic [30:0] lim);
    ray_t r;
    r.point_x = px; r.point_y = py; r.point_z = pz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz; r.step_limit = lim;
    ray_q.push_back(r);
  endtask

  initial begin
    ray_ch.valid = 1'b0;
    ray_ch.data = '0;
    res_ch.ready = 1'b0;
    for (int i = 0; i < 3; i++) begin
      box_c[i] = 0; box_h[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset box, then a unit box at the origin
    push_ray(32'h0, 32'h0, 32'h0, 32'h4000_0000, 32'h0, 32'h0, 31'h7FFF_FFFF);
    drain();
    set_box(32'h0, 32'h0, 32'h0, 31'h1_0000, 31'h1_0000, 31'h1_0000);
    push_ray(32'h0, 32'h0, 32'h0, 32'h4000_0000, 32'h0, 32'h0, 31'h7FFF_FFFF);
    push_ray(32'hFFFD_0000, 32'h0, 32'h0, 32'h4000_0000, 32'h0, 32'h0, 31'h7FFF_FFFF);
    push_ray(32'hFFFD_0000, 32'h0, 32'h0, 32'hC000_0000, 32'h0, 32'h0, 31'h7FFF_FFFF);
    push_ray(32'hFFFD_0000, 32'h0, 32'h0, 32'h0, 32'h4000_0000, 32'h0, 31'h7FFF_FFFF);
    push_ray(32'hFFFD_0000, 32'h0, 32'h0, 32'h4000_0000, 32'h0, 32'h0, 31'h1_0000);
    push_ray(32'h1_0000, 32'h0, 32'h0, 32'hC000_0000, 32'h0, 32'h0, 31'h7FFF_FFFF);
    push_ray(32'h3_0000, 32'h3_0000, 32'h0, 32'hD2BF_1D9B, 32'hD2BF_1D9B, 32'h0,
             31'h7FFF_FFFF);
    push_ray(32'h3_0000, 32'h3_0000, 32'h3_0000, 32'hDB0A_8D8A, 32'hDB0A_8D8A,
             32'hDB0A_8D8A, 31'h7FFF_FFFF);
    push_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0001, 31'h7FFF_FFFF);
    push_ray(32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 31'h7FFF_FFFF);
    push_ray(32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 31'h0);
    push_ray(32'hFFFD_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             31'h7FFF_FFFF);
    drain();
    set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
            31'h7FFF_FFFF);
    push_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000, 32'hC000_0000,
             32'h0, 31'h7FFF_FFFF);
    push_ray(32'h0, 32'h0, 32'h0, 32'h4000_0000, 32'h0, 32'h0, 31'h7FFF_FFFF);
    push_rand(20);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 62; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 62; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      if (ph == 7) set_box(32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0);
      else set_box($urandom(), $urandom(), $urandom(), $urandom_range(32'h0010_0000),
                   $urandom_range(32'h0010_0000), $urandom_range(32'h0010_0000));
      phase = ph;
      push_rand(145);
      drain();
    end
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_ray_if.sv
hw/rtl/rbd_res_if.sv
hw/rtl/rbd_div.sv
hw/rtl/ray_box_distance_from_outside_core.sv
test/tb.sv
